// ----- rtl/spc_pkg.sv -----
`default_nettype none
package spc_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int NUM_SLOTS   = 4;
    localparam int CODE_BITS   = 5;
    localparam int CODES_BITS  = CODE_BITS * NUM_SLOTS;
    localparam int COUNT_BITS  = 3;
    localparam int IDX_BITS    = $clog2(NUM_SLOTS);
    localparam int SUM_BITS    = SAMPLE_BITS + 1;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef sample_t [NUM_SLOTS-1:0]       sample_vec_t;
    typedef logic [CODE_BITS-1:0]          code_t;
    typedef logic [CODES_BITS-1:0]         codes_t;
    typedef logic [COUNT_BITS-1:0]         count_t;

    localparam sample_t SAMPLE_MAX = sample_t'({1'b0, {(SAMPLE_BITS-1){1'b1}}});
    localparam sample_t SAMPLE_MIN = sample_t'({1'b1, {(SAMPLE_BITS-1){1'b0}}});

    // polarization codes
    localparam code_t POL_I  = 5'd1;
    localparam code_t POL_Q  = 5'd2;
    localparam code_t POL_U  = 5'd3;
    localparam code_t POL_V  = 5'd4;
    localparam code_t POL_RR = 5'd5;
    localparam code_t POL_RL = 5'd6;
    localparam code_t POL_LR = 5'd7;
    localparam code_t POL_LL = 5'd8;
    localparam code_t POL_XX = 5'd9;
    localparam code_t POL_XY = 5'd10;
    localparam code_t POL_YX = 5'd11;
    localparam code_t POL_YY = 5'd12;

    // config register indexes
    localparam logic [1:0] REG_INPUT_CODES  = 2'd0;
    localparam logic [1:0] REG_OUTPUT_CODES = 2'd1;
    localparam logic [1:0] REG_INPUT_COUNT  = 2'd2;
    localparam logic [1:0] REG_OUTPUT_COUNT = 2'd3;

    localparam codes_t RST_INPUT_CODES  = 20'd269509;
    localparam codes_t RST_OUTPUT_CODES = 20'd134209;
    localparam count_t RST_COUNT        = 3'd4;

    typedef struct packed {
        logic                hit;
        logic [IDX_BITS-1:0] idx;
    } slot_ref_t;

    typedef struct packed {
        slot_ref_t rr;
        slot_ref_t rl;
        slot_ref_t lr;
        slot_ref_t ll;
        slot_ref_t xx;
        slot_ref_t xy;
        slot_ref_t yx;
        slot_ref_t yy;
    } pol_refs_t;

    // lowest active input slot carrying code
    function automatic slot_ref_t find_slot(codes_t codes, count_t count, code_t code);
        slot_ref_t r;
        r = '0;
        for (int k = NUM_SLOTS - 1; k >= 0; k--) begin
            if ((COUNT_BITS'(k) < count) && (codes[k*CODE_BITS +: CODE_BITS] == code)) begin
                r.hit = 1'b1;
                r.idx = IDX_BITS'(k);
            end
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/spc_slot.sv -----
`default_nettype none
module spc_slot (
    input  wire  spc_pkg::code_t       code,
    input  wire  logic                 slot_active,
    input  wire  spc_pkg::codes_t      in_codes,
    input  wire  spc_pkg::count_t      in_count,
    input  wire  spc_pkg::pol_refs_t   refs,
    input  wire  spc_pkg::sample_vec_t re_vec,
    input  wire  spc_pkg::sample_vec_t im_vec,
    output logic signed [spc_pkg::SAMPLE_BITS-1:0] out_re,
    output logic signed [spc_pkg::SAMPLE_BITS-1:0] out_im,
    output logic                       found
);
    import spc_pkg::*;

    slot_ref_t                    copy_ref;
    logic                         pair_ok;
    logic [IDX_BITS-1:0]          p_idx;
    logic [IDX_BITS-1:0]          q_idx;
    logic                         sub;
    logic                         rot;
    sample_t                      re_p, re_q, im_p, im_q;
    logic signed [SUM_BITS-1:0]   sum_re, sum_im;
    sample_t                      half_re, half_im, neg_im;

    always_comb begin
        copy_ref = find_slot(in_codes, in_count, code);
        pair_ok  = 1'b1;
        p_idx    = '0;
        q_idx    = '0;
        sub      = 1'b0;
        rot      = 1'b0;
        priority if (code == POL_I && refs.rr.hit && refs.ll.hit) begin
            p_idx = refs.rr.idx; q_idx = refs.ll.idx;
        end else if (code == POL_Q && refs.rl.hit && refs.lr.hit) begin
            p_idx = refs.rl.idx; q_idx = refs.lr.idx;
        end else if (code == POL_U && refs.rl.hit && refs.lr.hit) begin
            p_idx = refs.lr.idx; q_idx = refs.rl.idx; sub = 1'b1; rot = 1'b1;
        end else if (code == POL_V && refs.rr.hit && refs.ll.hit) begin
            p_idx = refs.rr.idx; q_idx = refs.ll.idx; sub = 1'b1;
        end else if (code == POL_I && refs.xx.hit && refs.yy.hit) begin
            p_idx = refs.xx.idx; q_idx = refs.yy.idx;
        end else if (code == POL_Q && refs.xx.hit && refs.yy.hit) begin
            p_idx = refs.xx.idx; q_idx = refs.yy.idx; sub = 1'b1;
        end else if (code == POL_U && refs.xy.hit && refs.yx.hit) begin
            p_idx = refs.xy.idx; q_idx = refs.yx.idx;
        end else if (code == POL_V && refs.xy.hit && refs.yx.hit) begin
            p_idx = refs.yx.idx; q_idx = refs.xy.idx; sub = 1'b1; rot = 1'b1;
        end else begin
            pair_ok = 1'b0;
        end

        re_p = $signed(re_vec[p_idx]);
        re_q = $signed(re_vec[q_idx]);
        im_p = $signed(im_vec[p_idx]);
        im_q = $signed(im_vec[q_idx]);
        sum_re = sub ? (SUM_BITS'(re_p) - SUM_BITS'(re_q)) : (SUM_BITS'(re_p) + SUM_BITS'(re_q));
        sum_im = sub ? (SUM_BITS'(im_p) - SUM_BITS'(im_q)) : (SUM_BITS'(im_p) + SUM_BITS'(im_q));
        // arithmetic shift right by one
        half_re = sum_re[SUM_BITS-1:1];
        half_im = sum_im[SUM_BITS-1:1];
        neg_im  = (half_im == SAMPLE_MIN) ? SAMPLE_MAX : -half_im;

        out_re = '0;
        out_im = '0;
        found  = 1'b0;
        if (slot_active) begin
            if (copy_ref.hit) begin
                out_re = $signed(re_vec[copy_ref.idx]);
                out_im = $signed(im_vec[copy_ref.idx]);
                found  = 1'b1;
            end else if (pair_ok) begin
                out_re = rot ? neg_im : half_re;
                out_im = rot ? half_re : half_im;
                found  = 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

// ----- rtl/polarization_to_stokes_converter_top.sv -----
// Each word passes the input register, then the result register.
// Throughput: one word per cycle unless m_ready stalls the output.
// s_ready is high whenever the input register is empty or moves forward.
// Reset (aresetn low, synchronous): both stages empty, config registers
// return to RR,RL,LR,LL in, I,Q,U,V out, four slots each.
`default_nettype none
module polarization_to_stokes_converter_top (
    input  wire  logic                          aclk,
    input  wire  logic                          aresetn,
    input  wire  logic                          cfg_valid,
    output logic                                cfg_ready,
    input  wire  logic [1:0]                    cfg_index,
    input  wire  logic [spc_pkg::CODES_BITS-1:0] cfg_data,
    input  wire  logic                          s_valid,
    output logic                                s_ready,
    input  wire  logic signed [spc_pkg::SAMPLE_BITS-1:0] s_corr0_re,
    input  wire  logic signed [spc_pkg::SAMPLE_BITS-1:0] s_corr0_im,
    input  wire  logic signed [spc_pkg::SAMPLE_BITS-1:0] s_corr1_re,
    input  wire  logic signed [spc_pkg::SAMPLE_BITS-1:0] s_corr1_im,
    input  wire  logic signed [spc_pkg::SAMPLE_BITS-1:0] s_corr2_re,
    input  wire  logic signed [spc_pkg::SAMPLE_BITS-1:0] s_corr2_im,
    input  wire  logic signed [spc_pkg::SAMPLE_BITS-1:0] s_corr3_re,
    input  wire  logic signed [spc_pkg::SAMPLE_BITS-1:0] s_corr3_im,
    output logic                                m_valid,
    input  wire  logic                          m_ready,
    output logic signed [spc_pkg::SAMPLE_BITS-1:0] m_stokes0_re,
    output logic signed [spc_pkg::SAMPLE_BITS-1:0] m_stokes0_im,
    output logic signed [spc_pkg::SAMPLE_BITS-1:0] m_stokes1_re,
    output logic signed [spc_pkg::SAMPLE_BITS-1:0] m_stokes1_im,
    output logic signed [spc_pkg::SAMPLE_BITS-1:0] m_stokes2_re,
    output logic signed [spc_pkg::SAMPLE_BITS-1:0] m_stokes2_im,
    output logic signed [spc_pkg::SAMPLE_BITS-1:0] m_stokes3_re,
    output logic signed [spc_pkg::SAMPLE_BITS-1:0] m_stokes3_im,
    output logic [spc_pkg::NUM_SLOTS-1:0]       m_path_found
);
    import spc_pkg::*;

    codes_t      input_codes_reg, output_codes_reg;
    count_t      input_count_reg, output_count_reg;

    logic        in_valid_reg;
    sample_vec_t re_reg, im_reg;
    logic        out_valid_reg;
    sample_vec_t st_re_reg, st_im_reg;
    logic [NUM_SLOTS-1:0] path_found_reg;

    logic        in_load, out_load, out_free;
    pol_refs_t   refs;
    sample_vec_t st_re_next, st_im_next;
    logic [NUM_SLOTS-1:0] path_found_next;
    logic [NUM_SLOTS-1:0] out_active;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            input_codes_reg  <= RST_INPUT_CODES;
            output_codes_reg <= RST_OUTPUT_CODES;
            input_count_reg  <= RST_COUNT;
            output_count_reg <= RST_COUNT;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_INPUT_CODES:  input_codes_reg  <= cfg_data;
                REG_OUTPUT_CODES: output_codes_reg <= cfg_data;
                REG_INPUT_COUNT:  input_count_reg  <= cfg_data[COUNT_BITS-1:0];
                REG_OUTPUT_COUNT: output_count_reg <= cfg_data[COUNT_BITS-1:0];
                default: ;
            endcase
        end
    end

    assign out_free = !out_valid_reg || m_ready;
    assign out_load = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || out_free;
    assign in_load  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready)
                in_valid_reg <= s_valid;
            if (out_free)
                out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_load) begin
            re_reg <= {s_corr3_re, s_corr2_re, s_corr1_re, s_corr0_re};
            im_reg <= {s_corr3_im, s_corr2_im, s_corr1_im, s_corr0_im};
        end
        if (out_load) begin
            st_re_reg      <= st_re_next;
            st_im_reg      <= st_im_next;
            path_found_reg <= path_found_next;
        end
    end

    always_comb begin
        refs.rr = find_slot(input_codes_reg, input_count_reg, POL_RR);
        refs.rl = find_slot(input_codes_reg, input_count_reg, POL_RL);
        refs.lr = find_slot(input_codes_reg, input_count_reg, POL_LR);
        refs.ll = find_slot(input_codes_reg, input_count_reg, POL_LL);
        refs.xx = find_slot(input_codes_reg, input_count_reg, POL_XX);
        refs.xy = find_slot(input_codes_reg, input_count_reg, POL_XY);
        refs.yx = find_slot(input_codes_reg, input_count_reg, POL_YX);
        refs.yy = find_slot(input_codes_reg, input_count_reg, POL_YY);
    end

    for (genvar k = 0; k < NUM_SLOTS; k++) begin : g_slot
        assign out_active[k] = COUNT_BITS'(k) < output_count_reg;
        spc_slot u_slot (
            .code        (output_codes_reg[k*CODE_BITS +: CODE_BITS]),
            .slot_active (out_active[k]),
            .in_codes    (input_codes_reg),
            .in_count    (input_count_reg),
            .refs        (refs),
            .re_vec      (re_reg),
            .im_vec      (im_reg),
            .out_re      (st_re_next[k]),
            .out_im      (st_im_next[k]),
            .found       (path_found_next[k])
        );
    end

    assign m_valid      = out_valid_reg;
    assign m_stokes0_re = st_re_reg[0];
    assign m_stokes0_im = st_im_reg[0];
    assign m_stokes1_re = st_re_reg[1];
    assign m_stokes1_im = st_im_reg[1];
    assign m_stokes2_re = st_re_reg[2];
    assign m_stokes2_im = st_im_reg[2];
    assign m_stokes3_re = st_re_reg[3];
    assign m_stokes3_im = st_im_reg[3];
    assign m_path_found = path_found_reg;

    a_inactive_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> (path_found_reg & ~$past(out_active)) == '0)
        else $error("inactive output slot flagged");

    a_no_path_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !path_found_reg[0] |-> st_re_reg[0] == '0 && st_im_reg[0] == '0)
        else $error("slot without path is not zero");

    a_empty_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_valid_reg |-> s_ready)
        else $error("empty input stage not ready");

    a_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !out_valid_reg |=> out_valid_reg)
        else $error("word did not reach result stage");

endmodule
`default_nettype wire
